// File: hdl/lphm_pkg.sv
// package for the linear probe hash map: sizes, codes and the command/status structs
// no dependencies
`default_nettype none
package lphm_pkg;
	localparam int SLOTS = 256;
	localparam int SW = $clog2(SLOTS);
	localparam int CW = SW + 1;

	localparam logic [2:0] ACT_SET = 3'd0;
	localparam logic [2:0] ACT_GET = 3'd1;
	localparam logic [2:0] ACT_REMOVE = 3'd2;
	localparam logic [2:0] ACT_FIND = 3'd3;
	localparam logic [2:0] ACT_CLEAR = 3'd4;

	localparam logic [1:0] MARK_EMPTY = 2'd0;
	localparam logic [1:0] MARK_LIVE = 2'd1;
	localparam logic [1:0] MARK_TOMB = 2'd2;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef enum logic [2:0] {
		SEL_HOME, SEL_NEXT, SEL_ZERO, SEL_FREE, SEL_HOLD
	} addr_sel_t;

	// controller to datapath
	typedef struct packed {
		logic load;         // capture request
		addr_sel_t asel;    // next read address
		logic rd;           // issue read of slot at address
		logic take_free;    // remember current slot as free
		logic clr_free;
		logic wr_mark;
		logic [1:0] mark;
		logic wr_kv;        // write key and value at write address
		logic wr_v;         // write value only
		logic wr_at_free;   // write address is the free slot
		logic clr_mark;     // clear mark at sweep address
		logic cnt_inc;
		logic cnt_dec;
		logic cnt_clr;
		logic res_load;     // capture result
		logic [1:0] res_status;
		logic res_new;
		logic res_val;      // out_value from read value
		logic res_key;      // out_key from read key
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [2:0] action;
		logic [1:0] mark;
		logic key_hit;
		logic val_hit;
		logic wrap;         // current slot is the last of the probe or scan
		logic cnt_zero;
	} dp_stat_t;
endpackage
`default_nettype wire

// File: hdl/lphm_ram.sv
// generic single write port RAM with registered read
// no dependencies
`default_nettype none
module lphm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: hdl/lphm_dp.sv
// datapath: request registers, key/value/mark memories, probe address, count, result
// depends on lphm_pkg, lphm_ram
`default_nettype none
module lphm_dp
	import lphm_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [2:0] in_action,
	input wire logic [63:0] in_key,
	input wire logic [63:0] in_value,
	input wire dp_cmd_t cmd,
	output dp_stat_t stat,
	output logic [1:0] status,
	output logic inserted_new,
	output logic [63:0] out_value,
	output logic [63:0] out_key,
	output logic [8:0] entry_count
);
	logic [2:0] action_q;
	logic [63:0] key_q, value_q;
	logic [SW-1:0] addr_q, home_q, free_q, nxt_addr, waddr;
	logic [CW-1:0] cnt_q;
	logic [63:0] rkey, rval;
	logic [1:0] rmark, mwdata;
	logic mwe;
	logic [SW-1:0] maddr;
	logic [31:0] hfold;

	assign hfold = key_q[31:0] ^ key_q[63:32];

	always_comb begin
		case (cmd.asel)
			SEL_HOME: nxt_addr = hfold[SW-1:0];
			SEL_NEXT: nxt_addr = addr_q + SW'(1);
			SEL_ZERO: nxt_addr = '0;
			SEL_FREE: nxt_addr = free_q;
			default:  nxt_addr = addr_q;
		endcase
	end

	assign waddr = cmd.wr_at_free ? free_q : addr_q;
	assign mwe = cmd.wr_mark | cmd.clr_mark;
	assign mwdata = cmd.clr_mark ? MARK_EMPTY : cmd.mark;
	assign maddr = cmd.wr_at_free ? free_q : addr_q;

	lphm_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_keys (
		.clk(clk), .we(cmd.wr_kv), .waddr(waddr), .wdata(key_q),
		.raddr(nxt_addr), .rdata(rkey)
	);
	lphm_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_vals (
		.clk(clk), .we(cmd.wr_kv | cmd.wr_v), .waddr(waddr), .wdata(value_q),
		.raddr(nxt_addr), .rdata(rval)
	);
	lphm_ram #(.WIDTH(2), .DEPTH(SLOTS)) u_marks (
		.clk(clk), .we(mwe), .waddr(maddr), .wdata(mwdata),
		.raddr(nxt_addr), .rdata(rmark)
	);

	// wrap marks the last slot of a probe or scan, after which every slot has been seen once
	assign stat.action = action_q;
	assign stat.mark = rmark;
	assign stat.key_hit = (rkey == key_q);
	assign stat.val_hit = (rval == value_q);
	assign stat.wrap = (action_q == ACT_FIND || action_q == ACT_CLEAR)
		? (addr_q == {SW{1'b1}}) : (addr_q + SW'(1) == home_q);
	assign stat.cnt_zero = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= in_key;
			value_q <= in_value;
		end
		if (cmd.rd && cmd.asel == SEL_HOME) begin
			home_q <= hfold[SW-1:0];
		end
		if (cmd.take_free) begin
			free_q <= addr_q;
		end
	end

	// reset starts a sweep from slot 0 that empties every mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			action_q <= ACT_CLEAR;
			addr_q <= '0;
			cnt_q <= '0;
			status <= ST_DONE;
			inserted_new <= 1'b0;
			out_value <= '0;
			out_key <= '0;
		end else begin
			if (cmd.load) begin
				action_q <= in_action;
			end
			if (cmd.rd) begin
				addr_q <= nxt_addr;
			end
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (cmd.res_load) begin
				status <= cmd.res_status;
				inserted_new <= cmd.res_new;
				out_value <= cmd.res_val ? rval : 64'd0;
				out_key <= cmd.res_key ? rkey : 64'd0;
			end
		end
	end
	assign entry_count = 9'(cnt_q);
endmodule
`default_nettype wire

// File: hdl/lphm_ctrl.sv
// controller: sequences probes, scans and the clearing sweep
// depends on lphm_pkg
`default_nettype none
module lphm_ctrl
	import lphm_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input wire logic out_stall,
	input wire dp_stat_t stat,
	output dp_cmd_t cmd
);
	typedef enum logic [2:0] {
		S_INIT, S_IDLE, S_START, S_PROBE, S_RES, S_OUT
	} state_t;

	state_t state_q;
	logic have_free_q;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.asel = SEL_HOLD;
		case (state_q)
			// empty every mark once after reset
			S_INIT: begin
				cmd.clr_mark = 1'b1;
				if (!stat.wrap) begin
					cmd.rd = 1'b1;
					cmd.asel = SEL_NEXT;
				end
			end
			S_IDLE: cmd.load = in_valid;
			S_START: begin
				cmd.rd = 1'b1;
				cmd.clr_free = 1'b1;
				cmd.asel = (stat.action == ACT_FIND || stat.action == ACT_CLEAR)
					? SEL_ZERO : SEL_HOME;
			end
			S_PROBE: begin
				case (stat.action)
					ACT_SET: begin
						if (stat.mark == MARK_LIVE && stat.key_hit) begin
							cmd.wr_v = 1'b1;
							cmd.res_load = 1'b1;
							cmd.res_status = ST_DONE;
						end else if (stat.mark == MARK_EMPTY) begin
							cmd.wr_kv = 1'b1;
							cmd.wr_mark = 1'b1;
							cmd.mark = MARK_LIVE;
							cmd.wr_at_free = have_free_q;
							cmd.cnt_inc = 1'b1;
							cmd.res_load = 1'b1;
							cmd.res_new = 1'b1;
						end else begin
							if (stat.mark != MARK_LIVE && !have_free_q) begin
								cmd.take_free = 1'b1;
							end
							if (stat.wrap) begin
								if (have_free_q || stat.mark != MARK_LIVE) begin
									// the one free slot may be the current one
									cmd.wr_kv = 1'b1;
									cmd.wr_mark = 1'b1;
									cmd.mark = MARK_LIVE;
									cmd.wr_at_free = have_free_q;
									cmd.cnt_inc = 1'b1;
									cmd.res_load = 1'b1;
									cmd.res_new = 1'b1;
								end else begin
									cmd.res_load = 1'b1;
									cmd.res_status = ST_FULL;
								end
							end else begin
								cmd.rd = 1'b1;
								cmd.asel = SEL_NEXT;
							end
						end
					end
					ACT_GET, ACT_REMOVE: begin
						if (stat.mark == MARK_LIVE && stat.key_hit) begin
							cmd.res_load = 1'b1;
							cmd.res_val = 1'b1;
							if (stat.action == ACT_REMOVE) begin
								cmd.wr_mark = 1'b1;
								cmd.mark = MARK_TOMB;
								cmd.cnt_dec = !stat.cnt_zero;
							end
						end else if (stat.mark == MARK_EMPTY || stat.wrap) begin
							cmd.res_load = 1'b1;
							cmd.res_status = ST_NOT_FOUND;
						end else begin
							cmd.rd = 1'b1;
							cmd.asel = SEL_NEXT;
						end
					end
					ACT_FIND: begin
						if (stat.mark == MARK_LIVE && stat.val_hit) begin
							cmd.res_load = 1'b1;
							cmd.res_key = 1'b1;
						end else if (stat.wrap) begin
							cmd.res_load = 1'b1;
							cmd.res_status = ST_NOT_FOUND;
						end else begin
							cmd.rd = 1'b1;
							cmd.asel = SEL_NEXT;
						end
					end
					ACT_CLEAR: begin
						cmd.clr_mark = 1'b1;
						cmd.cnt_clr = 1'b1;
						if (stat.wrap) begin
							cmd.res_load = 1'b1;
						end else begin
							cmd.rd = 1'b1;
							cmd.asel = SEL_NEXT;
						end
					end
					default: begin
						cmd.res_load = 1'b1;
						cmd.res_status = ST_NOT_FOUND;
					end
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			out_valid <= 1'b0;
			have_free_q <= 1'b0;
		end else begin
			if (cmd.clr_free) begin
				have_free_q <= 1'b0;
			end else if (cmd.take_free) begin
				have_free_q <= 1'b1;
			end
			case (state_q)
				S_INIT: if (stat.wrap) state_q <= S_IDLE;
				S_IDLE: if (in_valid) state_q <= S_START;
				S_START: state_q <= S_PROBE;
				S_PROBE: if (cmd.res_load) begin
					state_q <= S_OUT;
					out_valid <= 1'b1;
				end
				S_OUT: if (!out_stall) begin
					out_valid <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: hdl/linear_probe_hash_map.sv
// top level of the linear probe hash map: controller plus datapath
// depends on lphm_pkg, lphm_ctrl, lphm_dp
//
// channel   direction  handshake          payload
// request   in         in_valid/in_stall  action, key, value
// result    out        out_valid/out_stall status, inserted_new, out_value, out_key, entry_count
//
// one request at a time, probing slot by slot through the single
// read port of the slot memories (clear walks all 256 slots, value search up to 256)
// the result waits in its output registers until out_stall is low
// after reset a sweep over all 256 slots empties every mark; in_stall stays high meanwhile
`default_nettype none
module linear_probe_hash_map
	import lphm_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [2:0] action,
	input wire logic [63:0] key,
	input wire logic [63:0] value,
	output logic out_valid,
	input wire logic out_stall,
	output logic [1:0] status,
	output logic inserted_new,
	output logic [63:0] out_value,
	output logic [63:0] out_key,
	output logic [8:0] entry_count
);
	dp_cmd_t cmd;
	dp_stat_t stat;

	lphm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .stat(stat), .cmd(cmd)
	);

	lphm_dp u_dp (
		.clk(clk), .arst_n(arst_n), .in_action(action), .in_key(key),
		.in_value(value), .cmd(cmd), .stat(stat), .status(status),
		.inserted_new(inserted_new), .out_value(out_value), .out_key(out_key),
		.entry_count(entry_count)
	);
endmodule
`default_nettype wire

// File: dv/tb_linear_probe_hash_map.sv
// self-checking testbench for linear_probe_hash_map: directed and random requests
// with a table model kept in the bench, random idle on both channels
// depends on lphm_pkg and the linear_probe_hash_map rtl
`default_nettype none
module tb_linear_probe_hash_map
	import lphm_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT = 1500000;
	localparam int NSLOT = 256;

	typedef struct {
		logic [1:0] st;
		logic fresh;
		logic [63:0] val;
		logic [63:0] k;
		logic [8:0] cnt;
	} map_result_t;

	logic clk, arst_n;
	logic in_valid, in_stall;
	logic [2:0] action;
	logic [63:0] key, value;
	logic out_valid, out_stall;
	logic [1:0] status;
	logic inserted_new;
	logic [63:0] out_value, out_key;
	logic [8:0] entry_count;

	linear_probe_hash_map dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .key(key), .value(value),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .inserted_new(inserted_new),
		.out_value(out_value), .out_key(out_key), .entry_count(entry_count)
	);

	// bench copy of the table
	logic [63:0] tbl_keys [NSLOT];
	logic [63:0] tbl_vals [NSLOT];
	logic [1:0] tbl_marks [NSLOT];
	int unsigned tbl_count;

	map_result_t pending_results[$];
	int errors = 0;
	int cycles = 0;
	bit quiet;
	logic [63:0] key_pool [40];
	logic [63:0] val_pool [8];

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned home_of(logic [63:0] k);
		return (k[31:0] ^ k[63:32]) % NSLOT;
	endfunction

	// random key whose home slot is h
	function automatic logic [63:0] key_at(int unsigned h);
		logic [63:0] k;
		k = {$urandom, $urandom};
		k[7:0] = h[7:0] ^ k[39:32];
		return k;
	endfunction

	function automatic map_result_t model_request(logic [2:0] act, logic [63:0] k,
			logic [63:0] v);
		map_result_t r;
		int unsigned s, free_slot;
		bit have_free, found;
		r = '{ST_DONE, 1'b0, 64'd0, 64'd0, 9'd0};
		have_free = 0;
		found = 0;
		free_slot = 0;
		s = home_of(k);
		case (act)
			ACT_SET: begin
				for (int n = 0; n < NSLOT; n++) begin
					if (tbl_marks[s] == MARK_LIVE) begin
						if (tbl_keys[s] == k) begin
							found = 1;
							break;
						end
					end else if (tbl_marks[s] == MARK_EMPTY) begin
						if (!have_free) begin
							have_free = 1;
							free_slot = s;
						end
						break;
					end else if (!have_free) begin
						have_free = 1;
						free_slot = s;
					end
					s = (s + 1) % NSLOT;
				end
				if (found) begin
					tbl_vals[s] = v;
				end else if (have_free) begin
					tbl_keys[free_slot] = k;
					tbl_vals[free_slot] = v;
					tbl_marks[free_slot] = MARK_LIVE;
					tbl_count++;
					r.fresh = 1;
				end else begin
					r.st = ST_FULL;
				end
			end
			ACT_GET, ACT_REMOVE: begin
				for (int n = 0; n < NSLOT; n++) begin
					if (tbl_marks[s] == MARK_EMPTY)
						break;
					if (tbl_marks[s] == MARK_LIVE && tbl_keys[s] == k) begin
						found = 1;
						break;
					end
					s = (s + 1) % NSLOT;
				end
				if (!found) begin
					r.st = ST_NOT_FOUND;
				end else begin
					r.val = tbl_vals[s];
					if (act == ACT_REMOVE) begin
						tbl_marks[s] = MARK_TOMB;
						if (tbl_count > 0)
							tbl_count--;
					end
				end
			end
			ACT_FIND: begin
				r.st = ST_NOT_FOUND;
				for (int n = 0; n < NSLOT; n++) begin
					if (tbl_marks[n] == MARK_LIVE && tbl_vals[n] == v) begin
						r.k = tbl_keys[n];
						r.st = ST_DONE;
						break;
					end
				end
			end
			ACT_CLEAR: begin
				foreach (tbl_marks[i])
					tbl_marks[i] = MARK_EMPTY;
				tbl_count = 0;
			end
			default: r.st = ST_NOT_FOUND;
		endcase
		r.cnt = tbl_count[8:0];
		return r;
	endfunction

	// called at a rising edge; returns at the edge where the item was taken
	task automatic send_req(logic [2:0] act, logic [63:0] k, logic [63:0] v);
		int gap;
		gap = 0;
		if (!quiet && $urandom_range(0, 99) < 11)
			gap = $urandom_range(1, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		key <= k;
		value <= v;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(model_request(act, k, v));
	endtask

	always @(posedge clk) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= !quiet && ($urandom_range(0, 99) < 11);
	end

	always @(posedge clk) begin
		map_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: status %0d count %0d", status, entry_count);
			end else begin
				e = pending_results.pop_front();
				if (status !== e.st || inserted_new !== e.fresh || out_value !== e.val
						|| out_key !== e.k || entry_count !== e.cnt) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp st=%0d new=%0d val=%h key=%h cnt=%0d, got st=%0d new=%0d val=%h key=%h cnt=%0d",
							e.st, e.fresh, e.val, e.k, e.cnt,
							status, inserted_new, out_value, out_key, entry_count);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic test_basic();
		send_req(ACT_CLEAR, 64'd0, 64'd0);
		send_req(ACT_GET, 64'd0, 64'd0);
		send_req(ACT_REMOVE, '1, 64'd0);
		send_req(ACT_FIND, 64'd0, 64'd0);
		send_req(ACT_SET, 64'd0, '1);
		send_req(ACT_SET, '1, 64'd0);
		send_req(ACT_GET, '1, 64'd0);
		send_req(ACT_FIND, 64'd0, '1);
		send_req(ACT_SET, '1, 64'h8000_0000_0000_0001);
		send_req(3'd5, '1, '1);
		send_req(3'd6, 64'd0, 64'd0);
		send_req(3'd7, 64'h5555_aaaa_5555_aaaa, 64'haaaa_5555_aaaa_5555);
	endtask

	// collisions, tombstones and wrap at the end of the table
	task automatic test_chains();
		logic [63:0] a, b, c, d;
		a = key_at(254);
		b = key_at(254);
		c = key_at(254);
		d = key_at(255);
		send_req(ACT_SET, a, 64'd11);
		send_req(ACT_SET, b, 64'd22);
		send_req(ACT_SET, c, 64'd22);
		send_req(ACT_SET, d, 64'd44);
		send_req(ACT_REMOVE, b, 64'd0);
		send_req(ACT_GET, c, 64'd0);
		send_req(ACT_SET, c, 64'd33);
		send_req(ACT_SET, key_at(254), 64'd55);
		send_req(ACT_FIND, 64'd0, 64'd22);
		send_req(ACT_GET, b, 64'd0);
		send_req(ACT_GET, d, 64'd0);
		send_req(ACT_CLEAR, 64'd0, 64'd0);
	endtask

	task automatic test_full_table();
		logic [63:0] k0;
		k0 = {$urandom, $urandom};
		send_req(ACT_SET, k0, 64'd1);
		for (int i = 1; i < NSLOT; i++)
			send_req(ACT_SET, {$urandom, $urandom}, {$urandom, $urandom});
		send_req(ACT_SET, {$urandom, $urandom}, 64'd7);
		send_req(ACT_SET, k0, 64'd2);
		send_req(ACT_REMOVE, k0, 64'd0);
		send_req(ACT_SET, {$urandom, $urandom}, 64'd3);
		send_req(ACT_SET, {$urandom, $urandom}, 64'd4);
		send_req(ACT_CLEAR, 64'd0, 64'd0);
	endtask

	task automatic test_random(int n_items);
		int r;
		logic [2:0] act;
		logic [63:0] k, v;
		foreach (key_pool[i])
			key_pool[i] = key_at((250 + $urandom_range(0, 11)) % NSLOT);
		foreach (val_pool[i])
			val_pool[i] = {$urandom, $urandom};
		for (int i = 0; i < n_items; i++) begin
			quiet = (i >= 400 && i < 600);
			r = $urandom_range(0, 99);
			if (r < 38) act = ACT_SET;
			else if (r < 60) act = ACT_GET;
			else if (r < 82) act = ACT_REMOVE;
			else if (r < 93) act = ACT_FIND;
			else if (r < 96) act = ACT_CLEAR;
			else act = 3'($urandom_range(5, 7));
			k = ($urandom_range(0, 99) < 75) ? key_pool[$urandom_range(0, 39)]
				: {$urandom, $urandom};
			v = ($urandom_range(0, 99) < 50) ? val_pool[$urandom_range(0, 7)]
				: {$urandom, $urandom};
			send_req(act, k, v);
		end
		quiet = 0;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = '0;
		key = '0;
		value = '0;
		quiet = 0;
		tbl_count = 0;
		foreach (tbl_marks[i]) begin
			tbl_marks[i] = MARK_EMPTY;
			tbl_keys[i] = '0;
			tbl_vals[i] = '0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic();
		test_chains();
		test_full_table();
		test_random(700);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire
